### hw/rtl/dircls_pkg.sv
// ----------------------------------------------------------------------------
// dircls_pkg
// Shared types, constants and helpers of the microphone direction classifier.
// ----------------------------------------------------------------------------
package dircls_pkg;

   localparam int MIC_COUNT         = 4;
   localparam int MIC_W             = 2;
   localparam int RMS_W             = 32;
   localparam int Q16_W             = 17;
   localparam int WINDOW_FRAMES_DEF = 8;

   localparam int DIV_NUM_W  = 48;
   localparam int DIV_DEN_W  = 32;
   localparam int SQRT_IN_W  = 64;
   localparam int SQRT_OUT_W = 32;

   localparam logic [RMS_W-1:0] MIN_LEVEL_Q16 = 32'd655;
   localparam logic [Q16_W-1:0] FULL_Q16      = 17'd65536;
   localparam logic [Q16_W-1:0] CONF_BASE     = 17'd19661;

   localparam logic [1:0] MODE_NORM   = 2'd0;
   localparam logic [1:0] MODE_WINDOW = 2'd2;

   typedef enum logic [3:0] {
      DIR_F       = 4'd0,
      DIR_R       = 4'd1,
      DIR_B       = 4'd2,
      DIR_L       = 4'd3,
      DIR_FR      = 4'd4,
      DIR_RB      = 4'd5,
      DIR_BL      = 4'd6,
      DIR_LF      = 4'd7,
      DIR_OMNI    = 4'd8,
      DIR_UNKNOWN = 4'd9
   } dir_code_type;

   typedef enum logic [2:0] {
      REG_DIRECTION_MODE   = 3'd0,
      REG_BASELINE_RATE    = 3'd1,
      REG_SMOOTHING_RATE   = 3'd2,
      REG_MIN_BASELINE     = 3'd3,
      REG_GLOBAL_MEAN      = 3'd4,
      REG_SPREAD_LIMIT     = 3'd5,
      REG_MARGIN_MIN       = 3'd6,
      REG_MARGIN_FULL      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 start;
      logic [SQRT_IN_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   // adjacent pairs around the belt; opposite pairs are unknown
   function automatic dir_code_type pair_code(logic [MIC_W-1:0] a, logic [MIC_W-1:0] b);
      logic [MIC_COUNT-1:0] m;
      m = (4'b0001 << a) | (4'b0001 << b);
      unique case (m)
         4'b0011: pair_code = DIR_FR;
         4'b0110: pair_code = DIR_RB;
         4'b1100: pair_code = DIR_BL;
         4'b1001: pair_code = DIR_LF;
         default: pair_code = DIR_UNKNOWN;
      endcase
   endfunction

   // compare-and-swap schedule: (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
   function automatic logic [MIC_W-1:0] sort_first(logic [2:0] step);
      unique case (step)
         3'd0, 3'd1, 3'd2: sort_first = 2'd0;
         3'd3, 3'd4:       sort_first = 2'd1;
         default:          sort_first = 2'd2;
      endcase
   endfunction

   function automatic logic [MIC_W-1:0] sort_second(logic [2:0] step);
      unique case (step)
         3'd0:       sort_second = 2'd1;
         3'd1, 3'd3: sort_second = 2'd2;
         default:    sort_second = 2'd3;
      endcase
   endfunction

endpackage

### hw/rtl/dircls_div.sv
// ----------------------------------------------------------------------------
// dircls_div
// Restoring divider, one quotient bit per cycle, shared by every division.
// ----------------------------------------------------------------------------
module dircls_div (
   input  logic                              clock,
   input  logic                              reset,
   input  dircls_pkg::div_req_type           div_req,
   output dircls_pkg::unit_stat_type         div_stat,
   output logic [dircls_pkg::DIV_NUM_W-1:0]  quotient
);
   import dircls_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      qbit    = 1'b0;
      if (div_req.start) begin
         den_in  = div_req.divisor;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            qbit   = 1'b1;
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
         end
         // dividend bits leave at the top as quotient bits enter below
         quo_in = {quo_ff[DIV_NUM_W-2:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quotient      = quo_ff;

endmodule

### hw/rtl/dircls_sqrt.sv
// ----------------------------------------------------------------------------
// dircls_sqrt
// Integer square root, one result bit per cycle (floor of the root).
// ----------------------------------------------------------------------------
module dircls_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  dircls_pkg::sqrt_req_type           sqrt_req,
   output dircls_pkg::unit_stat_type          sqrt_stat,
   output logic [dircls_pkg::SQRT_OUT_W-1:0]  root
);
   import dircls_pkg::*;

   localparam int CNT_W = $clog2(SQRT_OUT_W + 1);
   localparam int REM_W = SQRT_OUT_W + 2;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SQRT_IN_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [SQRT_OUT_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]      rem_sh;
   logic [REM_W+1:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, rad_ff[SQRT_IN_W-1 -: 2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      if (sqrt_req.start) begin
         rad_in  = sqrt_req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(SQRT_OUT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQRT_IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[SQRT_OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[SQRT_OUT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sqrt_stat.busy = busy_ff;
   assign sqrt_stat.done = done_ff;
   assign root           = root_ff;

endmodule

### hw/rtl/mic_array_direction_classifier.sv
// ----------------------------------------------------------------------------
// mic_array_direction_classifier
// Per-frame direction decision for a four-microphone belt: baselines,
// smoothed normalized energy and the rms window live in on-chip memories.
//
//   channel  dir  handshake            beat contents
//   req_     in   req_valid/req_stall  four rms levels, freeze flag
//   rsp_     out  rsp_valid/rsp_stall  direction, confidence, class, margin,
//                                      leader and runner-up microphone
//   csr_     in   csr_we               register index, write data
//
// One frame at a time; the shared divider (four or eight runs per frame plus
// up to three in the decision) and the square root set the frame time.
// Reset is synchronous; no clearing pass, the first frame seeds all state.
// A waiting result does not block the next frame; the frame finishes only
// once the output register is free.
// ----------------------------------------------------------------------------
module mic_array_direction_classifier #(
   parameter int WINDOW_FRAMES = dircls_pkg::WINDOW_FRAMES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_rms_front,
   input  logic [31:0] req_rms_right,
   input  logic [31:0] req_rms_back,
   input  logic [31:0] req_rms_left,
   input  logic        req_freeze_baselines,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_direction_code,
   output logic [16:0] rsp_confidence,
   output logic        rsp_global_class,
   output logic [16:0] rsp_margin,
   output logic [1:0]  rsp_leader_mic,
   output logic [1:0]  rsp_runner_mic,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import dircls_pkg::*;

   localparam int HIST_DEPTH = MIC_COUNT * WINDOW_FRAMES;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int SLOT_W     = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
   localparam int CNT_W      = $clog2(WINDOW_FRAMES + 1);
   localparam int SUM_W      = RMS_W + CNT_W;
   localparam int STM_W      = SUM_W + 2 * RMS_W;

   typedef enum logic [20:0] {
      ST_IDLE  = 21'd1 << 0,
      ST_READ  = 21'd1 << 1,
      ST_LOAD  = 21'd1 << 2,
      ST_BASE  = 21'd1 << 3,
      ST_NDIV  = 21'd1 << 4,
      ST_SMUL  = 21'd1 << 5,
      ST_SMTH  = 21'd1 << 6,
      ST_AVG   = 21'd1 << 7,
      ST_NEXT  = 21'd1 << 8,
      ST_SORT  = 21'd1 << 9,
      ST_SQR   = 21'd1 << 10,
      ST_ACC   = 21'd1 << 11,
      ST_ROOT  = 21'd1 << 12,
      ST_RWAIT = 21'd1 << 13,
      ST_CV    = 21'd1 << 14,
      ST_CVGET = 21'd1 << 15,
      ST_CLASS = 21'd1 << 16,
      ST_MRG   = 21'd1 << 17,
      ST_CONF  = 21'd1 << 18,
      ST_DONE  = 21'd1 << 19,
      ST_DWAIT = 21'd1 << 20
   } state_type;

   // configuration
   logic [1:0]  mode_ff;
   logic [15:0] brate_ff, srate_ff, limit_ff, mmin_ff, mfull_ff;
   logic [31:0] minb_ff, gmean_ff;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [MIC_W-1:0] mic_ff, mic_in;
   logic [2:0]  step_ff, step_in;
   logic        seeded_ff, seeded_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [RMS_W-1:0] rms_ff [MIC_COUNT];
   logic [RMS_W-1:0] rms_in [MIC_COUNT];
   logic [RMS_W-1:0] vec_ff [MIC_COUNT];
   logic [RMS_W-1:0] vec_in [MIC_COUNT];
   logic [MIC_W-1:0] order_ff [MIC_COUNT];
   logic [MIC_W-1:0] order_in [MIC_COUNT];
   logic        freeze_ff, freeze_in;
   logic [31:0] base_ff, base_in, sm_ff, sm_in, old_ff, old_in, mean_ff, mean_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [47:0] prod_ff, prod_in, cv_ff, cv_in;
   logic [33:0] acc_ff, acc_in;
   logic [63:0] sq_ff, sq_in, sqp_ff, sqp_in;
   logic        lvok_ff, lvok_in, glob_ff, glob_in;
   logic [16:0] margin_ff, margin_in, conf_ff, conf_in;
   dir_code_type code_ff, code_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_code_ff, rsp_code_in;
   logic [16:0] rsp_conf_ff, rsp_conf_in, rsp_margin_ff, rsp_margin_in;
   logic        rsp_glob_ff, rsp_glob_in;
   logic [1:0]  rsp_lead_ff, rsp_lead_in, rsp_run_ff, rsp_run_in;

   // memories
   logic [STM_W-1:0] stm_mem [MIC_COUNT];
   logic [RMS_W-1:0] hist_mem [HIST_DEPTH];
   logic [STM_W-1:0] stm_q;
   logic [RMS_W-1:0] hist_q;
   logic             stm_we, hist_we;
   logic [ADDR_W-1:0] haddr;

   div_req_type   div_req;
   unit_stat_type div_stat;
   logic [DIV_NUM_W-1:0] div_quo;
   sqrt_req_type  sqrt_req;
   unit_stat_type sqrt_stat;
   logic [SQRT_OUT_W-1:0] sqrt_root;

   logic [31:0] rms_cur, floor_b, norm, dval, vfin;
   logic [15:0] limit;
   logic [CNT_W-1:0] cnt_new;
   logic [SUM_W-1:0] sum_new;
   logic [64:0] sq_sum;
   logic [16:0] m;
   logic [MIC_W-1:0] sa, sb;
   logic        is_glob;

   function automatic logic [31:0] blend_tail(logic [47:0] prod, logic [15:0] w,
                                              logic [31:0] old);
      logic [16:0] wc;
      logic [48:0] s;
      wc = 17'h10000 - {1'b0, w};
      s  = 49'(prod) + 49'(wc) * 49'(old) + 49'd32768;
      return s[47:16];
   endfunction

   dircls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_stat (div_stat),
      .quotient (div_quo)
   );

   dircls_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .sqrt_req  (sqrt_req),
      .sqrt_stat (sqrt_stat),
      .root      (sqrt_root)
   );

   assign rms_cur = rms_ff[mic_ff];
   assign floor_b = (minb_ff == '0) ? 32'd1 : minb_ff;
   assign limit   = (limit_ff == '0) ? 16'd1 : limit_ff;
   assign haddr   = ADDR_W'(int'(mic_ff) * WINDOW_FRAMES + int'(slot_ff));
   assign cnt_new = (count_ff == CNT_W'(WINDOW_FRAMES)) ? count_ff : count_ff + CNT_W'(1);
   // once the ring is full the slot holds the oldest beat: retire it
   assign sum_new = sum_ff + SUM_W'(rms_cur)
                    - ((count_ff == CNT_W'(WINDOW_FRAMES)) ? SUM_W'(old_ff) : '0);
   assign norm    = (div_quo[47:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
   assign dval    = (vec_ff[step_ff[1:0]] >= mean_ff) ? vec_ff[step_ff[1:0]] - mean_ff
                                                      : mean_ff - vec_ff[step_ff[1:0]];
   assign vfin    = (mode_ff == MODE_WINDOW) ? div_quo[31:0] : vec_ff[mic_ff];
   assign sq_sum  = {1'b0, sq_ff} + {1'b0, sqp_ff};
   assign m       = lvok_ff ? div_quo[16:0] : '0;
   assign sa      = sort_first(step_ff);
   assign sb      = sort_second(step_ff);
   assign is_glob = (cv_ff <= 48'(limit)) && !((mode_ff == MODE_NORM) && (mean_ff < gmean_ff));

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      mic_in     = mic_ff;
      step_in    = step_ff;
      seeded_in  = seeded_ff;
      slot_in    = slot_ff;
      count_in   = count_ff;
      rms_in     = rms_ff;
      vec_in     = vec_ff;
      order_in   = order_ff;
      freeze_in  = freeze_ff;
      base_in    = base_ff;
      sm_in      = sm_ff;
      old_in     = old_ff;
      sum_in     = sum_ff;
      prod_in    = prod_ff;
      mean_in    = mean_ff;
      acc_in     = acc_ff;
      sq_in      = sq_ff;
      sqp_in     = sqp_ff;
      cv_in      = cv_ff;
      lvok_in    = lvok_ff;
      glob_in    = glob_ff;
      margin_in  = margin_ff;
      conf_in    = conf_ff;
      code_in    = code_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_conf_in   = rsp_conf_ff;
      rsp_margin_in = rsp_margin_ff;
      rsp_glob_in   = rsp_glob_ff;
      rsp_lead_in   = rsp_lead_ff;
      rsp_run_in    = rsp_run_ff;
      stm_we     = 1'b0;
      hist_we    = 1'b0;
      div_req    = '0;
      sqrt_req   = '0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rms_in[0] = req_rms_front;
               rms_in[1] = req_rms_right;
               rms_in[2] = req_rms_back;
               rms_in[3] = req_rms_left;
               freeze_in = req_freeze_baselines;
               mic_in    = '0;
               acc_in    = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            base_in  = seeded_ff ? stm_q[31:0] : rms_cur;
            sm_in    = seeded_ff ? stm_q[63:32] : '0;
            sum_in   = seeded_ff ? stm_q[STM_W-1:64] : '0;
            old_in   = hist_q;
            prod_in  = 48'(brate_ff) * 48'(rms_cur);
            state_in = ST_BASE;
         end
         ST_BASE: begin
            if (!freeze_ff) base_in = blend_tail(prod_ff, brate_ff, base_ff);
            state_in = ST_NDIV;
         end
         ST_NDIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = {rms_cur, 16'h0000};
            div_req.divisor  = (base_ff < floor_b) ? floor_b : base_ff;
            ret_in   = ST_SMUL;
            state_in = ST_DWAIT;
         end
         ST_SMUL: begin
            prod_in  = 48'(srate_ff) * 48'(norm);
            state_in = ST_SMTH;
         end
         ST_SMTH: begin
            sm_in    = blend_tail(prod_ff, srate_ff, sm_ff);
            state_in = ST_AVG;
         end
         ST_AVG: begin
            stm_we          = 1'b1;
            hist_we         = 1'b1;
            vec_in[mic_ff]  = (mode_ff == MODE_NORM) ? sm_ff : rms_cur;
            if (mode_ff == MODE_WINDOW) begin
               div_req.start    = 1'b1;
               div_req.dividend = 48'(sum_new) + 48'(cnt_new >> 1);
               div_req.divisor  = 32'(cnt_new);
               ret_in   = ST_NEXT;
               state_in = ST_DWAIT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            vec_in[mic_ff] = vfin;
            acc_in         = acc_ff + 34'(vfin);
            if (mic_ff == MIC_W'(MIC_COUNT - 1)) begin
               seeded_in = 1'b1;
               count_in  = cnt_new;
               slot_in   = (slot_ff == SLOT_W'(WINDOW_FRAMES - 1)) ? '0 : slot_ff + SLOT_W'(1);
               step_in   = '0;
               for (int k = 0; k < MIC_COUNT; k++) order_in[k] = MIC_W'(k);
               state_in  = ST_SORT;
            end else begin
               mic_in   = mic_ff + MIC_W'(1);
               state_in = ST_READ;
            end
         end
         ST_SORT: begin
            // swap on strictly greater only, so a tie for the leader keeps the lower index
            if (vec_ff[sb] > vec_ff[sa]) begin
               vec_in[sa]   = vec_ff[sb];
               vec_in[sb]   = vec_ff[sa];
               order_in[sa] = order_ff[sb];
               order_in[sb] = order_ff[sa];
            end
            if (step_ff == 3'd5) begin
               mean_in  = acc_ff[33:2];
               step_in  = '0;
               sq_in    = '0;
               state_in = ST_SQR;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_SQR: begin
            sqp_in   = 64'(dval) * 64'(dval);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sq_in = sq_sum[64] ? '1 : sq_sum[63:0];
            if (step_ff == 3'd3) begin
               state_in = ST_ROOT;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_SQR;
            end
         end
         ST_ROOT: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = {2'b00, sq_ff[63:2]};
            state_in = ST_RWAIT;
         end
         ST_RWAIT: begin
            if (sqrt_stat.done) state_in = ST_CV;
         end
         ST_CV: begin
            if (mean_ff > MIN_LEVEL_Q16) begin
               div_req.start    = 1'b1;
               div_req.dividend = {sqrt_root, 16'h0000};
               div_req.divisor  = mean_ff;
               ret_in   = ST_CVGET;
               state_in = ST_DWAIT;
            end else begin
               cv_in    = 48'(FULL_Q16);
               state_in = ST_CLASS;
            end
         end
         ST_CVGET: begin
            cv_in    = div_quo;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            glob_in = is_glob;
            if (is_glob) begin
               code_in          = DIR_OMNI;
               margin_in        = '0;
               div_req.start    = 1'b1;
               div_req.dividend = {cv_ff[31:0], 16'h0000};
               div_req.divisor  = 32'(limit);
               ret_in   = ST_CONF;
               state_in = ST_DWAIT;
            end else if (vec_ff[0] > MIN_LEVEL_Q16) begin
               lvok_in          = 1'b1;
               div_req.start    = 1'b1;
               div_req.dividend = {vec_ff[0] - vec_ff[1], 16'h0000};
               div_req.divisor  = vec_ff[0];
               ret_in   = ST_MRG;
               state_in = ST_DWAIT;
            end else begin
               lvok_in  = 1'b0;
               state_in = ST_MRG;
            end
         end
         ST_MRG: begin
            margin_in = m;
            if (m >= {1'b0, mmin_ff}) begin
               code_in = dir_code_type'({2'b00, order_ff[0]});
               if (mfull_ff > mmin_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = 48'({m - {1'b0, mmin_ff}, 16'h0000});
                  div_req.divisor  = 32'(mfull_ff - mmin_ff);
                  ret_in   = ST_CONF;
                  state_in = ST_DWAIT;
               end else begin
                  conf_in  = FULL_Q16;
                  state_in = ST_DONE;
               end
            end else begin
               code_in          = pair_code(order_ff[0], order_ff[1]);
               div_req.start    = 1'b1;
               div_req.dividend = 48'({m, 17'h00000});
               div_req.divisor  = 32'({mmin_ff, 2'b00}) + 32'(mmin_ff);
               ret_in   = ST_CONF;
               state_in = ST_DWAIT;
            end
         end
         ST_CONF: begin
            if (glob_ff) begin
               conf_in = FULL_Q16 - div_quo[16:0];
            end else if (margin_ff >= {1'b0, mmin_ff}) begin
               conf_in = (div_quo > 48'(FULL_Q16)) ? FULL_Q16 : div_quo[16:0];
            end else begin
               conf_in = CONF_BASE + div_quo[16:0];
               if (code_ff == DIR_UNKNOWN) conf_in = (CONF_BASE + div_quo[16:0]) >> 1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = code_ff;
               rsp_conf_in   = conf_ff;
               rsp_margin_in = margin_ff;
               rsp_glob_in   = glob_ff;
               rsp_lead_in   = order_ff[0];
               rsp_run_in    = order_ff[1];
               state_in      = ST_IDLE;
            end
         end
         ST_DWAIT: begin
            if (div_stat.done) state_in = ret_ff;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stm_we) stm_mem[mic_ff] <= {sum_new, sm_ff, base_ff};
      stm_q <= stm_mem[mic_ff];
      if (hist_we) hist_mem[haddr] <= rms_cur;
      hist_q <= hist_mem[haddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORM;
         brate_ff  <= 16'd65;
         srate_ff  <= 16'd19661;
         minb_ff   <= 32'd655;
         gmean_ff  <= 32'd98304;
         limit_ff  <= 16'd13107;
         mmin_ff   <= 16'd13107;
         mfull_ff  <= 16'd39321;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_DIRECTION_MODE: mode_ff  <= csr_wdata[1:0];
            REG_BASELINE_RATE:  brate_ff <= csr_wdata[15:0];
            REG_SMOOTHING_RATE: srate_ff <= csr_wdata[15:0];
            REG_MIN_BASELINE:   minb_ff  <= csr_wdata;
            REG_GLOBAL_MEAN:    gmean_ff <= csr_wdata;
            REG_SPREAD_LIMIT:   limit_ff <= csr_wdata[15:0];
            REG_MARGIN_MIN:     mmin_ff  <= csr_wdata[15:0];
            REG_MARGIN_FULL:    mfull_ff <= csr_wdata[15:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         mic_ff       <= '0;
         step_ff      <= '0;
         seeded_ff    <= 1'b0;
         slot_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         mic_ff       <= mic_in;
         step_ff      <= step_in;
         seeded_ff    <= seeded_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rms_ff        <= rms_in;
      vec_ff        <= vec_in;
      order_ff      <= order_in;
      freeze_ff     <= freeze_in;
      base_ff       <= base_in;
      sm_ff         <= sm_in;
      old_ff        <= old_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      mean_ff       <= mean_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      sqp_ff        <= sqp_in;
      cv_ff         <= cv_in;
      lvok_ff       <= lvok_in;
      glob_ff       <= glob_in;
      margin_ff     <= margin_in;
      conf_ff       <= conf_in;
      code_ff       <= code_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_conf_ff   <= rsp_conf_in;
      rsp_margin_ff <= rsp_margin_in;
      rsp_glob_ff   <= rsp_glob_in;
      rsp_lead_ff   <= rsp_lead_in;
      rsp_run_ff    <= rsp_run_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_direction_code = rsp_code_ff;
   assign rsp_confidence     = rsp_conf_ff;
   assign rsp_global_class   = rsp_glob_ff;
   assign rsp_margin         = rsp_margin_ff;
   assign rsp_leader_mic     = rsp_lead_ff;
   assign rsp_runner_mic     = rsp_run_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_global_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_global_class |-> rsp_direction_code == DIR_OMNI && rsp_margin == '0)
      else $error("global beat with direction or margin");

   a_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_leader_mic != rsp_runner_mic)
      else $error("leader and runner-up coincide");

   a_conf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_confidence <= FULL_Q16 && rsp_direction_code <= DIR_UNKNOWN)
      else $error("confidence or direction out of range");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the belt direction classifier. Frames go in from a
// queue through a clocked driver with random gaps; every accepted frame runs
// through a bit-exact predictor of baselines, smoothing, the rms window and
// the decision. A clocked monitor with random and long stalls compares each
// result beat with the oldest prediction. Several register settings,
// extremes included, are visited between idle points.
// ----------------------------------------------------------------------------
module tb_top;
   import dircls_pkg::*;

   localparam logic [1:0] MODE_RAW   = 2'd1;
   localparam logic [1:0] MODE_ALIAS = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int SETTLE_CYCLES  = 700;

   typedef struct packed {
      logic [3:0][31:0] rms;
      logic             freeze;
   } frame_type;

   typedef struct packed {
      dir_code_type code;
      logic [16:0]  conf;
      logic         glob;
      logic [16:0]  margin;
      logic [1:0]   lead;
      logic [1:0]   run;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_rms_front, req_rms_right, req_rms_back, req_rms_left;
   logic        req_freeze_baselines;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_direction_code;
   logic [16:0] rsp_confidence;
   logic        rsp_global_class;
   logic [16:0] rsp_margin;
   logic [1:0]  rsp_leader_mic, rsp_runner_mic;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   mic_array_direction_classifier dut (.*);

   // predictor copy of registers and state
   logic [1:0]  cfg_mode;
   logic [15:0] cfg_base_rate, cfg_smooth_rate;
   logic [31:0] cfg_min_base, cfg_mean_level;
   logic [15:0] cfg_spread, cfg_mmin, cfg_mfull;
   logic [31:0] base_lvl [4];
   logic [31:0] smooth_lvl [4];
   logic [31:0] hist [4][8];
   int unsigned hist_slot, hist_count;
   bit          seeded;

   frame_type   pending_frames[$];
   verdict_type expected_verdicts[$];
   int          errors = 0;
   bit          no_idle = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] blend(logic [15:0] w, logic [31:0] fresh, logic [31:0] old);
      logic [63:0] s;
      s = 64'(w) * fresh + (64'd65536 - w) * old + 64'd32768;
      return s[47:16];
   endfunction

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else
            res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic verdict_type decide(logic [31:0] e [4], bit use_mean);
      verdict_type vd;
      int order [4];
      int t;
      logic [63:0] sum, sq, d, d2, cv, conf, mg, lim;
      logic [31:0] mean, lv, rv;
      bit glob;
      order = '{0, 1, 2, 3};
      for (int i = 0; i < 4; i++)
         for (int j = i + 1; j < 4; j++)
            if (e[order[j]] > e[order[i]]) begin
               t = order[i]; order[i] = order[j]; order[j] = t;
            end
      sum = 0; sq = 0; mg = 0;
      for (int i = 0; i < 4; i++) sum += e[i];
      mean = sum[33:2];
      for (int i = 0; i < 4; i++) begin
         d = (e[i] >= mean) ? 64'(e[i] - mean) : 64'(mean - e[i]);
         d2 = d * d;
         sq = (sq > ~64'd0 - d2) ? ~64'd0 : sq + d2;
      end
      cv = (mean > MIN_LEVEL_Q16) ? (isqrt(sq >> 2) << 16) / mean : 64'd65536;
      lim = (cfg_spread == 0) ? 64'd1 : 64'(cfg_spread);
      glob = (cv <= lim);
      if (use_mean && mean < cfg_mean_level) glob = 0;
      if (glob) begin
         vd.code = DIR_OMNI;
         conf = 64'd65536 - (cv * 64'd65536) / lim;
      end else begin
         lv = e[order[0]];
         rv = e[order[1]];
         if (lv > MIN_LEVEL_Q16) mg = (64'(lv - rv) << 16) / lv;
         if (mg >= cfg_mmin) begin
            vd.code = dir_code_type'(4'(order[0]));
            if (cfg_mfull > cfg_mmin) begin
               conf = ((mg - cfg_mmin) << 16) / (cfg_mfull - cfg_mmin);
               if (conf > 64'd65536) conf = 64'd65536;
            end else
               conf = 64'd65536;
         end else begin
            vd.code = pair_code(2'(order[0]), 2'(order[1]));
            conf = 64'(CONF_BASE) + (64'd131072 * mg) / (64'd5 * cfg_mmin);
            if (vd.code == DIR_UNKNOWN) conf >>= 1;
         end
      end
      vd.conf = conf[16:0];
      vd.glob = glob;
      vd.margin = mg[16:0];
      vd.lead = 2'(order[0]);
      vd.run = 2'(order[1]);
      return vd;
   endfunction

   task automatic predict_frame(frame_type f);
      logic [31:0] raw [4], avg [4];
      logic [31:0] floor_b, safe;
      logic [63:0] norm, s;
      floor_b = (cfg_min_base == 0) ? 32'd1 : cfg_min_base;
      if (!seeded) begin
         for (int i = 0; i < 4; i++) base_lvl[i] = f.rms[i];
         seeded = 1;
      end
      for (int i = 0; i < 4; i++) begin
         if (!f.freeze) base_lvl[i] = blend(cfg_base_rate, f.rms[i], base_lvl[i]);
         safe = (base_lvl[i] < floor_b) ? floor_b : base_lvl[i];
         norm = (64'(f.rms[i]) << 16) / safe;
         if (norm > 64'hFFFF_FFFF) norm = 64'hFFFF_FFFF;
         smooth_lvl[i] = blend(cfg_smooth_rate, norm[31:0], smooth_lvl[i]);
         raw[i] = f.rms[i];
         hist[i][hist_slot] = f.rms[i];
      end
      hist_slot = (hist_slot + 1) % 8;
      if (hist_count < 8) hist_count++;
      for (int i = 0; i < 4; i++) begin
         s = 0;
         for (int w = 0; w < hist_count; w++) s += hist[i][w];
         s = (s + hist_count / 2) / hist_count;
         avg[i] = s[31:0];
      end
      if (cfg_mode == MODE_NORM) expected_verdicts.push_back(decide(smooth_lvl, 1));
      else if (cfg_mode == MODE_WINDOW) expected_verdicts.push_back(decide(avg, 0));
      else expected_verdicts.push_back(decide(raw, 0));
   endtask

   // driver
   int unsigned send_gap;
   always @(posedge clock) begin
      frame_type f;
      if (reset) begin
         req_valid <= 0;
         send_gap <= 0;
      end else if (req_valid && !req_stall) begin
         predict_frame({req_rms_left, req_rms_back, req_rms_right, req_rms_front,
                        req_freeze_baselines});
         req_valid <= 0;
         send_gap <= no_idle ? 0 : $urandom_range(0, 13);
      end else if (!req_valid) begin
         if (send_gap > 0)
            send_gap <= send_gap - 1;
         else if (pending_frames.size() > 0) begin
            f = pending_frames.pop_front();
            req_rms_front <= f.rms[0];
            req_rms_right <= f.rms[1];
            req_rms_back <= f.rms[2];
            req_rms_left <= f.rms[3];
            req_freeze_baselines <= f.freeze;
            req_valid <= 1;
         end
      end
   end

   // monitor
   int unsigned stall_left, hold_left, results_seen;
   always @(posedge clock) begin
      verdict_type ex;
      int unsigned nxt;
      if (reset) begin
         rsp_stall <= 0;
         stall_left <= 0;
         hold_left <= 0;
         results_seen <= 0;
      end else begin
         nxt = (stall_left > 0) ? stall_left - 1 : 0;
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_verdicts.size() == 0) begin
               $error("result beat with nothing expected");
               errors++;
            end else begin
               ex = expected_verdicts.pop_front();
               if (rsp_direction_code !== ex.code) begin
                  $error("direction_code expected %0d got %0d", ex.code, rsp_direction_code);
                  errors++;
               end
               if (rsp_confidence !== ex.conf) begin
                  $error("confidence expected %0d got %0d", ex.conf, rsp_confidence);
                  errors++;
               end
               if (rsp_global_class !== ex.glob) begin
                  $error("global_class expected %0d got %0d", ex.glob, rsp_global_class);
                  errors++;
               end
               if (rsp_margin !== ex.margin) begin
                  $error("margin expected %0d got %0d", ex.margin, rsp_margin);
                  errors++;
               end
               if (rsp_leader_mic !== ex.lead) begin
                  $error("leader_mic expected %0d got %0d", ex.lead, rsp_leader_mic);
                  errors++;
               end
               if (rsp_runner_mic !== ex.run) begin
                  $error("runner_mic expected %0d got %0d", ex.run, rsp_runner_mic);
                  errors++;
               end
            end
            nxt = no_idle ? 0 : $urandom_range(0, 13);
         end
         stall_left <= nxt;
         // long hold-off once, so the block backs up onto its input
         if (results_seen == 300 && rsp_valid && !rsp_stall) begin
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1;
         end else begin
            if (hold_left > 0) hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1) || (nxt != 0);
         end
      end
   end

   // watchdog
   int unsigned quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   task automatic write_reg(csr_index_type idx, logic [31:0] v);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         REG_DIRECTION_MODE: cfg_mode = v[1:0];
         REG_BASELINE_RATE:  cfg_base_rate = v[15:0];
         REG_SMOOTHING_RATE: cfg_smooth_rate = v[15:0];
         REG_MIN_BASELINE:   cfg_min_base = v;
         REG_GLOBAL_MEAN:    cfg_mean_level = v;
         REG_SPREAD_LIMIT:   cfg_spread = v[15:0];
         REG_MARGIN_MIN:     cfg_mmin = v[15:0];
         REG_MARGIN_FULL:    cfg_mfull = v[15:0];
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic wait_idle();
      while (pending_frames.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic frame_type make_frame(int pattern);
      frame_type f;
      logic [31:0] lvl;
      int k;
      lvl = $urandom_range(0, 32'h1000_0000) >> $urandom_range(0, 20);
      k = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) f.rms[i] = lvl - (lvl >> $urandom_range(1, 12));
      case (pattern)
         0: for (int i = 0; i < 4; i++) f.rms[i] = $urandom;
         1: f.rms[k] = lvl * $urandom_range(1, 8);
         2: begin
            f.rms[k] = lvl * 4;
            f.rms[(k + 1) % 4] = lvl * 4 - (lvl >> $urandom_range(0, 6));
         end
         3: begin
            f.rms[k] = lvl * 4;
            f.rms[(k + 2) % 4] = lvl * 4 - (lvl >> $urandom_range(0, 6));
         end
         4: for (int i = 0; i < 4; i++) f.rms[i] = lvl + $urandom_range(0, lvl >> 6);
         5: for (int i = 0; i < 4; i++) f.rms[i] = $urandom_range(0, 1500);
         default: for (int i = 0; i < 4; i++) f.rms[i] = lvl * $urandom_range(1, 8);
      endcase
      f.freeze = ($urandom_range(0, 3) == 0);
      return f;
   endfunction

   task automatic queue_random(int count);
      for (int n = 0; n < count; n++) pending_frames.push_back(make_frame($urandom_range(0, 6)));
   endtask

   task automatic queue_directed();
      frame_type f;
      logic [31:0] lv [4];
      f.freeze = 0;
      f.rms = '0;                                 pending_frames.push_back(f);
      f.rms = {4{32'hFFFF_FFFF}};                 pending_frames.push_back(f);
      f.rms = {4{32'd100000}};                    pending_frames.push_back(f);
      f.rms = {4{32'd200000}};                    pending_frames.push_back(f);
      // ties resolve to the earliest index
      f.rms = {32'd50000, 32'd900000, 32'd50000, 32'd900000}; pending_frames.push_back(f);
      f.rms = {32'd900000, 32'd900000, 32'd900000, 32'd1000}; pending_frames.push_back(f);
      // each single leader, then each adjacent pair, then both opposite pairs
      for (int k = 0; k < 4; k++) begin
         lv = '{32'd70000, 32'd70000, 32'd70000, 32'd70000};
         lv[k] = 32'd3000000;
         f.rms = {lv[3], lv[2], lv[1], lv[0]};
         pending_frames.push_back(f);
      end
      for (int k = 0; k < 4; k++) begin
         lv = '{32'd70000, 32'd70000, 32'd70000, 32'd70000};
         lv[k] = 32'd3000000;
         lv[(k + 1) % 4] = 32'd2900000;
         f.rms = {lv[3], lv[2], lv[1], lv[0]};
         pending_frames.push_back(f);
      end
      f.rms = {32'd70000, 32'd2900000, 32'd70000, 32'd3000000}; pending_frames.push_back(f);
      f.rms = {32'd2950000, 32'd70000, 32'd3000000, 32'd70000}; pending_frames.push_back(f);
      // frozen baselines, levels under the floor, one mic at full scale
      f.freeze = 1;
      f.rms = {32'd40, 32'd654, 32'd655, 32'd656};          pending_frames.push_back(f);
      f.rms = {32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};         pending_frames.push_back(f);
      f.freeze = 0;
      f.rms = {32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF};         pending_frames.push_back(f);
      f.rms = {32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 32'h0000_FFFF};
      pending_frames.push_back(f);
   endtask

   task automatic random_settings(logic [1:0] mode);
      write_reg(REG_DIRECTION_MODE, 32'(mode));
      write_reg(REG_BASELINE_RATE, $urandom_range(0, 65535));
      write_reg(REG_SMOOTHING_RATE, $urandom_range(0, 65535));
      write_reg(REG_MIN_BASELINE, $urandom_range(1, 200000));
      write_reg(REG_GLOBAL_MEAN, $urandom_range(0, 200000));
      write_reg(REG_SPREAD_LIMIT, $urandom_range(1, 40000));
      write_reg(REG_MARGIN_MIN, $urandom_range(1, 40000));
      write_reg(REG_MARGIN_FULL, $urandom_range(0, 65535));
      end_writes();
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_rms_front = 0; req_rms_right = 0; req_rms_back = 0; req_rms_left = 0;
      req_freeze_baselines = 0;
      rsp_stall = 0;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      cfg_mode = MODE_NORM; cfg_base_rate = 65; cfg_smooth_rate = 19661;
      cfg_min_base = 655; cfg_mean_level = 98304; cfg_spread = 13107;
      cfg_mmin = 13107; cfg_mfull = 39321;
      for (int i = 0; i < 4; i++) begin
         base_lvl[i] = 0;
         smooth_lvl[i] = 0;
      end
      hist_slot = 0; hist_count = 0; seeded = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // reset settings: directed frames, then a random run with the hold-off
      queue_directed();
      queue_random(330);
      wait_idle();

      // raw and window modes, directed again
      random_settings(MODE_RAW);
      queue_directed();
      queue_random(60);
      wait_idle();
      random_settings(MODE_WINDOW);
      queue_random(100);
      wait_idle();

      // extremes: zero floor, zero limit, zero margins, full baseline rate, zero smoothing rate
      no_idle = 1;
      write_reg(REG_DIRECTION_MODE, 32'(MODE_NORM));
      write_reg(REG_BASELINE_RATE, 32'd65535);
      write_reg(REG_SMOOTHING_RATE, 32'd0);
      write_reg(REG_MIN_BASELINE, 32'd0);
      write_reg(REG_GLOBAL_MEAN, 32'd0);
      write_reg(REG_SPREAD_LIMIT, 32'd0);
      write_reg(REG_MARGIN_MIN, 32'd0);
      write_reg(REG_MARGIN_FULL, 32'd0);
      end_writes();
      queue_random(80);
      wait_idle();

      no_idle = 0;
      write_reg(REG_DIRECTION_MODE, 32'(MODE_ALIAS));
      write_reg(REG_BASELINE_RATE, 32'd0);
      write_reg(REG_SMOOTHING_RATE, 32'd65535);
      write_reg(REG_MIN_BASELINE, 32'hFFFF_FFFF);
      write_reg(REG_GLOBAL_MEAN, 32'hFFFF_FFFF);
      write_reg(REG_SPREAD_LIMIT, 32'd65535);
      write_reg(REG_MARGIN_MIN, 32'd65535);
      write_reg(REG_MARGIN_FULL, 32'd65535);
      end_writes();
      queue_random(80);
      wait_idle();

      write_reg(REG_DIRECTION_MODE, 32'(MODE_NORM));
      write_reg(REG_MIN_BASELINE, 32'd1);
      write_reg(REG_GLOBAL_MEAN, 32'd0);
      write_reg(REG_SPREAD_LIMIT, 32'd1);
      write_reg(REG_MARGIN_MIN, 32'd1);
      end_writes();
      queue_random(80);
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         no_idle = (p == 2);
         random_settings(2'(p));
         queue_random(80);
         wait_idle();
      end
      no_idle = 0;
      random_settings(MODE_WINDOW);
      queue_random(60);
      wait_idle();

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/dircls_pkg.sv
hw/rtl/dircls_div.sv
hw/rtl/dircls_sqrt.sv
hw/rtl/mic_array_direction_classifier.sv
dv/tb_top.sv
